@@ hdl/tzpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tzpc_pkg
// Shared constants and types of the zone people counter.
// ----------------------------------------------------------------------------
package tzpc_pkg;

	// default parameter values
	localparam int COUNT_BITS_DEF    = 16;
	localparam int DISTANCE_BITS_DEF = 12;

	// frame geometry
	localparam int ROWS   = 4;
	localparam int PIXELS = 16;

	// fixed field widths
	localparam int TRIG_W      = 12;
	localparam int SHOWN_W     = 16;
	localparam int OUT_TDATA_W = 32;

	// distance constants in mm
	localparam int DEFAULT_TRIGGER = 1500;
	localparam int NEAR_LIMIT      = 200;
	localparam int MARGIN          = 100;
	localparam int NO_TARGET       = 9999;
	localparam int MAX_BAD_ROWS    = 2;

	// register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_TRIGGER_IDX = '0;

	// pixel stage to frame logic
	typedef struct packed {
		logic            frame_end;
		logic            is_cal;
		logic [ROWS-1:0] hit_rows;
		logic [ROWS-1:0] dis_rows;
	} frame_info_t;

	// result word fields
	typedef struct packed {
		logic               was_cal;
		logic [SHOWN_W-1:0] people_count;
		logic               occupied;
		logic [ROWS-1:0]    rows_triggered;
		logic [ROWS-1:0]    rows_available;
		logic [1:0]         entry_row;
		logic [1:0]         exit_row;
		logic               fault;
	} result_t;

endpackage

@@ hdl/tzpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tzpc_cfg_regs
// Configuration register file with a simple peripheral bus port.
// ----------------------------------------------------------------------------
module tzpc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tzpc_pkg::PADDR_W-1:0] paddr,
	input  logic [tzpc_pkg::PDATA_W-1:0] pwdata,
	output logic [tzpc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic [tzpc_pkg::TRIG_W-1:0]  trigger
);

	logic [tzpc_pkg::TRIG_W-1:0] trigger_q;
	logic                        hit_trig;

	// address decode on word index
	assign hit_trig = (paddr[tzpc_pkg::PADDR_W-1:2] == tzpc_pkg::REG_TRIGGER_IDX);
	assign pready   = 1'b1;
	assign trigger  = trigger_q;

	// write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= tzpc_pkg::TRIG_W'(tzpc_pkg::DEFAULT_TRIGGER);
		end else if (psel && penable && pwrite && pready && hit_trig) begin
			trigger_q <= pwdata[tzpc_pkg::TRIG_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit_trig) begin
			prdata = tzpc_pkg::PDATA_W'(trigger_q);
		end
	end

endmodule

@@ hdl/tzpc_pixel_stage.sv @@
// ----------------------------------------------------------------------------
// tzpc_pixel_stage
// Per-pixel thresholds and the row hit and row disable accumulators.
// ----------------------------------------------------------------------------
module tzpc_pixel_stage #(
	parameter int DISTANCE_BITS = tzpc_pkg::DISTANCE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic                        op,
	input  logic [3:0]                  idx,
	input  logic                        found,
	input  logic [DISTANCE_BITS-1:0]    dist_mm,
	input  logic [tzpc_pkg::TRIG_W-1:0] trigger,
	output tzpc_pkg::frame_info_t       info
);

	localparam int EFF_W = (DISTANCE_BITS > 14) ? DISTANCE_BITS : 14;

	logic [DISTANCE_BITS-1:0]  thr_q [tzpc_pkg::PIXELS];
	logic [tzpc_pkg::ROWS-1:0] hit_q;
	logic [tzpc_pkg::ROWS-1:0] dis_q;
	logic [tzpc_pkg::ROWS-1:0] hit_nxt;
	logic [tzpc_pkg::ROWS-1:0] dis_nxt;
	logic [EFF_W-1:0]          eff;
	logic [EFF_W-1:0]          eff_sub;
	logic [1:0]                row;
	logic [DISTANCE_BITS-1:0]  thr_rd;
	logic [DISTANCE_BITS-1:0]  thr_new;
	logic                      near;
	logic                      below;
	logic                      frame_end;

	// threshold compare and accumulator update
	always_comb begin
		eff       = found ? EFF_W'(dist_mm) : EFF_W'(tzpc_pkg::NO_TARGET);
		eff_sub   = eff - EFF_W'(tzpc_pkg::NEAR_LIMIT);
		row       = idx[3:2];
		thr_rd    = thr_q[idx];
		near      = (eff <= EFF_W'(tzpc_pkg::NEAR_LIMIT));
		below     = (eff < (EFF_W'(trigger) + EFF_W'(tzpc_pkg::MARGIN)));
		frame_end = (idx == 4'hF);
		if (near) begin
			thr_new = DISTANCE_BITS'(1);
		end else if (below) begin
			thr_new = eff_sub[DISTANCE_BITS-1:0];
		end else begin
			thr_new = DISTANCE_BITS'(trigger);
		end
		hit_nxt = hit_q;
		dis_nxt = dis_q;
		if (op) begin
			if (!near) begin
				dis_nxt[row] = 1'b0;
			end
		end else if (eff < EFF_W'(thr_rd)) begin
			hit_nxt[row] = 1'b1;
		end
		info.frame_end = frame_end;
		info.is_cal    = op;
		info.hit_rows  = hit_nxt;
		info.dis_rows  = dis_nxt;
	end

	// threshold store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tzpc_pkg::PIXELS; i++) begin
				thr_q[i] <= DISTANCE_BITS'(tzpc_pkg::DEFAULT_TRIGGER);
			end
		end else if (upd && op) begin
			thr_q[idx] <= thr_new;
		end
	end

	// accumulators, restarted at every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
			dis_q <= '1;
		end else if (upd) begin
			if (frame_end) begin
				hit_q <= '0;
				dis_q <= '1;
			end else begin
				hit_q <= hit_nxt;
				dis_q <= dis_nxt;
			end
		end
	end

endmodule

@@ hdl/tzpc_frame_logic.sv @@
// ----------------------------------------------------------------------------
// tzpc_frame_logic
// Row setup at calibration end and entry/exit crossing counter.
// ----------------------------------------------------------------------------
module tzpc_frame_logic #(
	parameter int COUNT_BITS = tzpc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  tzpc_pkg::frame_info_t info,
	output tzpc_pkg::result_t     res
);

	logic [tzpc_pkg::ROWS-1:0] avail_q, avail_nxt;
	logic [1:0]                entry_q, entry_nxt;
	logic [1:0]                exit_q, exit_nxt;
	logic                      en_arm_q, en_arm_nxt;
	logic                      ex_arm_q, ex_arm_nxt;
	logic [COUNT_BITS-1:0]     occ_q, occ_nxt;
	logic                      fault_q, fault_nxt;
	logic [tzpc_pkg::ROWS-1:0] trig;
	logic [2:0]                bad_rows;
	logic                      en_av, ex_av, en_hit, ex_hit;
	logic [31:0]               occ_wide;

	// next state at frame end
	always_comb begin
		avail_nxt  = avail_q;
		entry_nxt  = entry_q;
		exit_nxt   = exit_q;
		en_arm_nxt = en_arm_q;
		ex_arm_nxt = ex_arm_q;
		occ_nxt    = occ_q;
		fault_nxt  = fault_q;
		trig       = info.hit_rows & avail_q;
		bad_rows   = 3'(info.dis_rows[0]) + 3'(info.dis_rows[1])
		           + 3'(info.dis_rows[2]) + 3'(info.dis_rows[3]);
		en_av      = avail_q[entry_q];
		ex_av      = avail_q[exit_q];
		en_hit     = trig[entry_q];
		ex_hit     = trig[exit_q];
		if (info.is_cal) begin
			// pick outermost usable rows, defaults 1 and 2
			avail_nxt  = ~info.dis_rows;
			fault_nxt  = (bad_rows > 3'(tzpc_pkg::MAX_BAD_ROWS));
			entry_nxt  = avail_nxt[0] ? 2'd0 : 2'd1;
			exit_nxt   = avail_nxt[3] ? 2'd3 : 2'd2;
			en_arm_nxt = 1'b0;
			ex_arm_nxt = 1'b0;
		end else if (fault_q) begin
			en_arm_nxt = 1'b0;
			ex_arm_nxt = 1'b0;
		end else begin
			// entry clear and exit hit: crossing inward completes
			if (en_av && !en_hit && ex_av && ex_hit) begin
				if (en_arm_q) begin
					if (occ_q != '1) begin
						occ_nxt = occ_q + COUNT_BITS'(1);
					end
					en_arm_nxt = 1'b0;
				end
				ex_arm_nxt = 1'b1;
			end
			// entry hit and exit clear: crossing outward completes
			if (en_av && en_hit && ex_av && !ex_hit) begin
				if (ex_arm_q && (occ_q != '0)) begin
					occ_nxt    = occ_q - COUNT_BITS'(1);
					ex_arm_nxt = 1'b0;
				end
				en_arm_nxt = 1'b1;
			end
			if (trig == '0) begin
				en_arm_nxt = 1'b0;
				ex_arm_nxt = 1'b0;
			end
		end
	end

	// result fields from the updated state
	always_comb begin
		occ_wide           = 32'(occ_nxt);
		res.was_cal        = info.is_cal;
		res.people_count   = (occ_wide > 32'h0000_FFFF) ? 16'hFFFF : occ_wide[15:0];
		res.occupied       = (occ_nxt != '0);
		res.rows_triggered = info.is_cal ? '0 : trig;
		res.rows_available = avail_nxt;
		res.entry_row      = entry_nxt;
		res.exit_row       = exit_nxt;
		res.fault          = fault_nxt;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q  <= '1;
			entry_q  <= 2'd1;
			exit_q   <= 2'd2;
			en_arm_q <= 1'b0;
			ex_arm_q <= 1'b0;
			occ_q    <= '0;
			fault_q  <= 1'b0;
		end else if (upd && info.frame_end) begin
			avail_q  <= avail_nxt;
			entry_q  <= entry_nxt;
			exit_q   <= exit_nxt;
			en_arm_q <= en_arm_nxt;
			ex_arm_q <= ex_arm_nxt;
			occ_q    <= occ_nxt;
			fault_q  <= fault_nxt;
		end
	end

endmodule

@@ hdl/tof_zone_people_counter_unit.sv @@
// ----------------------------------------------------------------------------
// tof_zone_people_counter_unit
// Zone people counter over 4x4 time-of-flight depth frames.
//
// Pixels stream in one word per clock outside stalls, in any order, with
// pixel 15 closing the frame; the tuser bit tells calibration from
// measurement pixels. Each word is taken into an input register and
// handled by one threshold compare and the frame-end logic; the result word
// enters the output register as pixel 15 leaves the input register. Only
// pixel 15 produces a word. The input stalls only while a frame-end pixel
// waits for the output register to drain. The threshold store comes out of
// reset loaded, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tof_zone_people_counter_unit #(
	parameter int COUNT_BITS    = tzpc_pkg::COUNT_BITS_DEF,
	parameter int DISTANCE_BITS = tzpc_pkg::DISTANCE_BITS_DEF,
	parameter int IN_TDATA_W    = ((5 + DISTANCE_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pixel_index[3:0], target_found, distance_mm, zero fill
	input  logic [IN_TDATA_W-1:0]            s_tdata,
	// operation
	input  logic                             s_tuser,
	// frame result
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// people_count[15:0], occupied, rows_triggered[3:0], rows_available[3:0],
	// entry_row[1:0], exit_row[1:0], calibration_fault, zero fill
	output logic [tzpc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// was_calibration
	output logic                             m_tuser,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tzpc_pkg::PADDR_W-1:0]     paddr,
	input  logic [tzpc_pkg::PDATA_W-1:0]     pwdata,
	output logic [tzpc_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	logic                        valid_s1;
	logic                        op_s1;
	logic [3:0]                  idx_s1;
	logic                        found_s1;
	logic [DISTANCE_BITS-1:0]    dist_s1;
	logic                        adv;
	logic                        frame_end;
	logic [tzpc_pkg::TRIG_W-1:0] trigger;
	tzpc_pkg::frame_info_t       info;
	tzpc_pkg::result_t           res;
	logic                        out_valid_q;
	logic [tzpc_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                        out_user_q;

	// flow control: only a frame-end word needs room at the output
	assign frame_end = (idx_s1 == 4'hF);
	assign adv       = valid_s1 && (!frame_end || !out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser;
			idx_s1   <= s_tdata[3:0];
			found_s1 <= s_tdata[4];
			dist_s1  <= s_tdata[5 +: DISTANCE_BITS];
		end
	end

	tzpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.trigger (trigger)
	);

	tzpc_pixel_stage #(
		.DISTANCE_BITS (DISTANCE_BITS)
	) u_pixel (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (adv),
		.op      (op_s1),
		.idx     (idx_s1),
		.found   (found_s1),
		.dist_mm (dist_s1),
		.trigger (trigger),
		.info    (info)
	);

	tzpc_frame_logic #(
		.COUNT_BITS (COUNT_BITS)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.info   (info),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && frame_end) begin
			out_user_q <= res.was_cal;
			out_data_q <= {2'b00, res.fault, res.exit_row, res.entry_row,
				res.rows_available, res.rows_triggered, res.occupied,
				res.people_count};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ hdl/tzpc_checker.sv @@
// ----------------------------------------------------------------------------
// tzpc_checker
// Port-level checks on the frame result words of the people counter.
// ----------------------------------------------------------------------------
module tzpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tzpc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// occupied flag agrees with the count
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16] == (m_tdata[15:0] != 16'h0000)))
		else $error("occupied flag does not match count");

	// calibration words report no triggered rows
	a_cal_trig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[20:17] == 4'h0))
		else $error("triggered rows on calibration word");

	// fault set exactly when more than two rows are unavailable
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[29] == ($countones(~m_tdata[24:21]) > 2)))
		else $error("fault flag does not match available rows");

	// entry row in the lower half, exit row in the upper half
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[26] && m_tdata[28]))
		else $error("entry or exit row out of place");

endmodule

bind tof_zone_people_counter_unit tzpc_checker u_tzpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
